// ===== rtl/hks_pkg.sv =====
// ----------------------------------------------------------------------------
// hks_pkg
// Shared widths, codes and the bin hash for the hashed key set.
// ----------------------------------------------------------------------------
package hks_pkg;

	localparam int HASH_BITS = 8;
	localparam int CAPACITY  = 1024;

	localparam int NBINS   = 1 << HASH_BITS;
	localparam int BIN_W   = HASH_BITS;
	localparam int KEY_W   = 32;
	localparam int START_W = 8;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NODE_W  = KEY_W + CNT_W;

	localparam logic [CNT_W-1:0] NIL      = CNT_W'(CAPACITY);
	localparam logic [KEY_W-1:0] HASH_MUL = 32'h61C8_8647;

	typedef logic [1:0] op_t;
	localparam op_t OP_INSERT   = 2'd0;
	localparam op_t OP_DELETE   = 2'd1;
	localparam op_t OP_CONTAINS = 2'd2;

	// top bits of the golden-ratio product
	function automatic logic [BIN_W-1:0] bin_of(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] prod;
		prod = k * HASH_MUL;
		return prod[KEY_W-1 -: BIN_W];
	endfunction

endpackage

// ===== rtl/hks_ram.sv =====
// ----------------------------------------------------------------------------
// hks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hks_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
	input  logic [W-1:0]                        wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
	output logic [W-1:0]                        rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/hashed_key_set_with_eviction.sv =====
// ----------------------------------------------------------------------------
// hashed_key_set_with_eviction
// Chained hash set of 32-bit keys with eviction at capacity.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer around three RAMs: bin heads,
// nodes (key and next link together) and the free-slot stack. Each item
// hashes its key to a bin, then walks that bin's chain (node RAM read,
// compare, follow link) until the key is found or the chain ends. A full
// insert first scans bins from evict_start and evicts the head node of the
// first non-empty one; a new key then pops a slot from the free stack and is
// linked in as the new bin head. A finished item waits in S_DONE while the
// previous result is held by out_stall. Bin emptiness lives in one flop per
// bin, cleared at reset, so no clearing pass is needed; the free stack reads
// unpopped positions as their own index via a low-water mark. in_stall is
// high while an item is in progress; a finished result waits in the output
// register.
module hashed_key_set_with_eviction (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [hks_pkg::KEY_W-1:0]   key,
	input  logic [hks_pkg::START_W-1:0] evict_start,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic                        evicted,
	output logic [hks_pkg::KEY_W-1:0]   evicted_key,
	output logic [hks_pkg::CNT_W-1:0]   item_total
);
	import hks_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HASH  = 4'd1;
	localparam logic [3:0] S_EVSC  = 4'd2;
	localparam logic [3:0] S_EVHW  = 4'd3;
	localparam logic [3:0] S_EVNW  = 4'd4;
	localparam logic [3:0] S_FHEAD = 4'd5;
	localparam logic [3:0] S_FHW   = 4'd6;
	localparam logic [3:0] S_FNODE = 4'd7;
	localparam logic [3:0] S_FNW   = 4'd8;
	localparam logic [3:0] S_FEND  = 4'd9;
	localparam logic [3:0] S_POP   = 4'd10;
	localparam logic [3:0] S_POPW  = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0]         state_q;
	op_t                op_q;
	logic [KEY_W-1:0]   key_q;
	logic [BIN_W-1:0]   bin_q;
	logic [BIN_W-1:0]   scan_q;
	logic [BIN_W:0]     scan_cnt_q;
	logic [CNT_W-1:0]   cur_q, prev_q, head_q, nxt_q, guard_q;
	logic [KEY_W-1:0]   prev_key_q;
	logic               found_q, ok_q, ev_q;
	logic [KEY_W-1:0]   victim_q;
	logic [CNT_W-1:0]   total_q, top_q, low_q;
	logic [NBINS-1:0]   busy_bin_q;   // bin head is not null
	logic               out_valid_q;
	logic               out_ok_q, out_ev_q;
	logic [KEY_W-1:0]   out_vkey_q;
	logic [CNT_W-1:0]   out_total_q;

	// RAM ports
	logic               h_we, n_we, f_we;
	logic [BIN_W-1:0]   h_waddr, h_raddr;
	logic [CNT_W-1:0]   h_wdata, h_rdata;
	logic [SLOT_W-1:0]  n_waddr, n_raddr, f_waddr, f_raddr;
	logic [NODE_W-1:0]  n_wdata, n_rdata;
	logic [SLOT_W-1:0]  f_wdata, f_rdata;

	hks_ram #(.W(CNT_W), .D(NBINS)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);
	hks_ram #(.W(NODE_W), .D(CAPACITY)) u_node (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);
	hks_ram #(.W(SLOT_W), .D(CAPACITY)) u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	logic [KEY_W-1:0]   rd_key;
	logic [CNT_W-1:0]   rd_next;
	logic [CNT_W-1:0]   pop_idx;
	logic               pop_fresh;
	logic [CNT_W-1:0]   pop_slot;

	assign rd_key  = n_rdata[NODE_W-1 -: KEY_W];
	assign rd_next = n_rdata[CNT_W-1:0];
	assign pop_idx = top_q - CNT_W'(1);
	// stack position below the low-water mark was never pushed: holds its index
	assign pop_fresh = (pop_idx < low_q);

	always_comb begin
		pop_slot = pop_fresh ? pop_idx : CNT_W'(f_rdata);
		if (pop_slot >= NIL) begin
			pop_slot = '0;
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign evicted     = out_ev_q;
	assign evicted_key = out_vkey_q;
	assign item_total  = out_total_q;

	// RAM addressing and write-back
	always_comb begin
		h_we    = 1'b0;
		h_waddr = bin_q;
		h_wdata = NIL;
		h_raddr = bin_q;
		n_we    = 1'b0;
		n_waddr = prev_q[SLOT_W-1:0];
		n_wdata = {prev_key_q, nxt_q};
		n_raddr = cur_q[SLOT_W-1:0];
		f_we    = 1'b0;
		f_waddr = top_q[SLOT_W-1:0];
		f_wdata = cur_q[SLOT_W-1:0];
		f_raddr = pop_idx[SLOT_W-1:0];
		unique case (state_q)
			S_EVSC: begin
				h_raddr = scan_q;
			end
			S_EVHW: begin
				n_raddr = h_rdata[SLOT_W-1:0];
			end
			S_EVNW: begin
				h_we    = 1'b1;
				h_waddr = scan_q;
				h_wdata = rd_next;
				f_we    = (top_q < NIL);
			end
			S_FEND: begin
				if (op_q == OP_DELETE && found_q) begin
					if (prev_q == NIL) begin
						h_we    = 1'b1;
						h_wdata = nxt_q;
					end else begin
						n_we = 1'b1;
					end
					f_we = (top_q < NIL);
				end
			end
			S_POPW: begin
				h_we    = 1'b1;
				h_wdata = pop_slot;
				n_we    = 1'b1;
				n_waddr = pop_slot[SLOT_W-1:0];
				n_wdata = {key_q, head_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			top_q       <= NIL;
			low_q       <= NIL;
			busy_bin_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// S_DONE loads the output register itself
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						key_q   <= key;
						scan_q  <= BIN_W'(evict_start);
						found_q <= 1'b0;
						ok_q    <= 1'b0;
						ev_q    <= 1'b0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					bin_q      <= bin_of(key_q);
					scan_cnt_q <= '0;
					if (op_q == OP_INSERT && total_q >= NIL) begin
						state_q <= S_EVSC;
					end else begin
						state_q <= S_FHEAD;
					end
				end
				S_EVSC: begin
					priority if (scan_cnt_q == (BIN_W+1)'(NBINS)) begin
						state_q <= S_FHEAD;
					end else if (busy_bin_q[scan_q]) begin
						state_q <= S_EVHW;
					end else begin
						scan_q     <= scan_q + BIN_W'(1);
						scan_cnt_q <= scan_cnt_q + (BIN_W+1)'(1);
					end
				end
				S_EVHW: begin
					cur_q   <= h_rdata;
					state_q <= S_EVNW;
				end
				S_EVNW: begin
					victim_q          <= rd_key;
					ev_q              <= 1'b1;
					busy_bin_q[scan_q] <= (rd_next != NIL);
					if (top_q < NIL) begin
						top_q <= top_q + CNT_W'(1);
					end
					if (total_q != '0) begin
						total_q <= total_q - CNT_W'(1);
					end
					state_q <= S_FHEAD;
				end
				S_FHEAD: begin
					prev_q  <= NIL;
					guard_q <= '0;
					if (busy_bin_q[bin_q]) begin
						state_q <= S_FHW;
					end else begin
						head_q  <= NIL;
						state_q <= S_FEND;
					end
				end
				S_FHW: begin
					head_q  <= h_rdata;
					cur_q   <= h_rdata;
					state_q <= S_FNODE;
				end
				S_FNODE: begin
					if (cur_q < NIL && guard_q < NIL) begin
						state_q <= S_FNW;
					end else begin
						state_q <= S_FEND;
					end
				end
				S_FNW: begin
					if (rd_key == key_q) begin
						found_q <= 1'b1;
						nxt_q   <= rd_next;
						state_q <= S_FEND;
					end else begin
						prev_q     <= cur_q;
						prev_key_q <= rd_key;
						cur_q      <= rd_next;
						guard_q    <= guard_q + CNT_W'(1);
						state_q    <= S_FNODE;
					end
				end
				S_FEND: begin
					state_q <= S_DONE;
					unique case (op_q)
						OP_INSERT: begin
							if (!found_q && top_q != '0) begin
								state_q <= S_POP;
							end
						end
						OP_DELETE: begin
							if (found_q) begin
								ok_q <= 1'b1;
								if (prev_q == NIL) begin
									busy_bin_q[bin_q] <= (nxt_q != NIL);
								end
								if (top_q < NIL) begin
									top_q <= top_q + CNT_W'(1);
								end
								if (total_q != '0) begin
									total_q <= total_q - CNT_W'(1);
								end
							end
						end
						OP_CONTAINS: begin
							ok_q <= found_q;
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					state_q <= S_POPW;
				end
				S_POPW: begin
					busy_bin_q[bin_q] <= 1'b1;
					top_q   <= pop_idx;
					if (pop_fresh) begin
						low_q <= pop_idx;
					end
					total_q <= total_q + CNT_W'(1);
					ok_q    <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= ok_q;
						out_ev_q    <= ev_q;
						out_vkey_q  <= ev_q ? victim_q : '0;
						out_total_q <= total_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
